@@ design/irfp_pkg.sv @@
// Shared types and constants for the serial IMU rotation-vector frame parser.
// No dependencies; imported by irfp_collector and imu_rvc_frame_parser_core.
package irfp_pkg;

   // Sync byte that opens every frame, sent twice in a row.
   localparam logic [7:0] SYNC_BYTE = 8'hAA;

   // Frame bytes kept for unpacking: index, six words, three reserved bytes.
   localparam int FRAME_BODY = 16;

   // Byte position codes. Position 2 expects the index byte and position 18
   // expects the checksum byte.
   typedef logic [4:0] pos_type;
   localparam pos_type POS_HUNT1 = 5'd0;
   localparam pos_type POS_HUNT2 = 5'd1;
   localparam pos_type POS_FIRST = 5'd2;
   localparam pos_type POS_CHECK = 5'd18;

   // One decoded frame as it leaves the parser.
   typedef struct packed {
      logic [7:0]         frame_index;
      logic signed [15:0] yaw;
      logic signed [15:0] pitch;
      logic signed [15:0] roll;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic               checksum_ok;
   } frame_type;

   // What the collector hands to the output stage for the current byte.
   typedef struct packed {
      logic      done;
      frame_type frame;
   } collect_type;

endpackage

@@ design/imu_rvc_frame_parser_core.sv @@
// Top level of the serial IMU rotation-vector frame parser.
// Depends on irfp_pkg and instantiates irfp_collector.
//
// Usage:
//   The req_ channel carries one received serial byte per beat (req_rx_byte).
//   The parser hunts for two 0xAA sync bytes, collects the 16 frame bytes that
//   follow and, on the checksum byte, presents one beat on the rsp_ channel:
//   the index byte, yaw, pitch and roll in 0.01 degree, x/y/z acceleration in
//   milli-g, and checksum_ok. Bytes other than a checksum byte give no beat.
//   csr_we with csr_wdata sets drop_bad_frames; when set, frames whose
//   checksum mismatches give no beat. Write it only while the block is idle.
//   The result beat is valid in the cycle after its checksum byte is accepted.
//   Throughput: one byte per cycle unless a beat waits on a stalled receiver,
//   set by the combinational parse step from frame byte to output registers.
//   Reset (synchronous, active high) returns the parser to sync hunting,
//   clears drop_bad_frames and empties the output register.
//   When the receiver stalls, the result beat holds; a further byte is taken
//   in the same cycle the pending beat is taken, so no beat is lost.
module imu_rvc_frame_parser_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_frame_index,
   output logic signed [15:0] rsp_yaw,
   output logic signed [15:0] rsp_pitch,
   output logic signed [15:0] rsp_roll,
   output logic signed [15:0] rsp_accel_x,
   output logic signed [15:0] rsp_accel_y,
   output logic signed [15:0] rsp_accel_z,
   output logic               rsp_checksum_ok,
   input  logic               csr_we,
   input  logic               csr_wdata
);
   import irfp_pkg::*;

   logic        drop_bad_ff;
   logic        rsp_valid_ff;
   frame_type   rsp_frame_ff;
   logic        req_accept;
   collect_type col;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         drop_bad_ff <= 1'b0;
      end else if (csr_we) begin
         drop_bad_ff <= csr_wdata;
      end
   end

   // Take a byte whenever the output register is empty or being drained.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   irfp_collector u_collector (
      .clock    (clock),
      .reset    (reset),
      .step     (req_accept),
      .rx_byte  (req_rx_byte),
      .drop_bad (drop_bad_ff),
      .result   (col)
   );

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (col.done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (col.done) begin
         rsp_frame_ff <= col.frame;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_frame_index = rsp_frame_ff.frame_index;
   assign rsp_yaw         = rsp_frame_ff.yaw;
   assign rsp_pitch       = rsp_frame_ff.pitch;
   assign rsp_roll        = rsp_frame_ff.roll;
   assign rsp_accel_x     = rsp_frame_ff.accel_x;
   assign rsp_accel_y     = rsp_frame_ff.accel_y;
   assign rsp_accel_z     = rsp_frame_ff.accel_z;
   assign rsp_checksum_ok = rsp_frame_ff.checksum_ok;

   // A result beat appears only after a byte was accepted.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept))
      else $error("result beat without an accepted byte");

   // With dropping enabled, a freshly loaded result always has a good checksum.
   assert property (@(posedge clock) disable iff (reset)
      $past(col.done) && $past(drop_bad_ff) |-> rsp_checksum_ok)
      else $error("bad frame passed while dropping is enabled");

   // A completed frame is never loaded over a beat the receiver has not taken.
   assert property (@(posedge clock) disable iff (reset)
      col.done |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending result beat overwritten");

endmodule

@@ design/irfp_collector.sv @@
// Sync hunt, frame byte collection and running checksum for the frame parser.
// Depends on irfp_pkg for the position codes and the frame types.
module irfp_collector (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   input  logic                drop_bad,
   output irfp_pkg::collect_type result
);
   import irfp_pkg::*;

   pos_type    pos_ff;
   pos_type    pos_in;
   logic [7:0] sum_ff;
   logic [7:0] sum_in;
   logic       shift;
   logic       at_check;
   logic       sum_ok;

   // Newest byte enters at entry 0; after 16 shifts the index byte sits at 15.
   logic [7:0] frame_ff [FRAME_BODY];

   // Next position and running sum for the byte on the input.
   always_comb begin
      pos_in = pos_ff;
      sum_in = sum_ff;
      shift  = 1'b0;
      case (pos_ff)
         POS_HUNT1: begin
            pos_in = (rx_byte == SYNC_BYTE) ? POS_HUNT2 : POS_HUNT1;
         end
         POS_HUNT2: begin
            pos_in = (rx_byte == SYNC_BYTE) ? POS_FIRST : POS_HUNT1;
            sum_in = 8'd0;
         end
         default: begin
            if (pos_ff < POS_CHECK) begin
               shift  = 1'b1;
               sum_in = sum_ff + rx_byte;
               pos_in = pos_ff + 5'd1;
            end else begin
               pos_in = POS_HUNT1;
            end
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT1;
         sum_ff <= 8'd0;
      end else if (step) begin
         pos_ff <= pos_in;
         sum_ff <= sum_in;
      end
   end

   // Frame byte shift line.
   always_ff @(posedge clock) begin
      if (step && shift) begin
         frame_ff[0] <= rx_byte;
         for (int i = 1; i < FRAME_BODY; i++) begin
            frame_ff[i] <= frame_ff[i-1];
         end
      end
   end

   // Unpack the little-endian words; frame byte j is at entry 15 - j.
   assign at_check = (pos_ff == POS_CHECK);
   assign sum_ok   = (sum_ff == rx_byte);

   always_comb begin
      result.done               = step && at_check && (sum_ok || !drop_bad);
      result.frame.frame_index  = frame_ff[15];
      result.frame.yaw          = {frame_ff[13], frame_ff[14]};
      result.frame.pitch        = {frame_ff[11], frame_ff[12]};
      result.frame.roll         = {frame_ff[9],  frame_ff[10]};
      result.frame.accel_x      = {frame_ff[7],  frame_ff[8]};
      result.frame.accel_y      = {frame_ff[5],  frame_ff[6]};
      result.frame.accel_z      = {frame_ff[3],  frame_ff[4]};
      result.frame.checksum_ok  = sum_ok;
   end

   // The position never leaves the range of defined codes.
   assert property (@(posedge clock) disable iff (reset) pos_ff <= POS_CHECK)
      else $error("byte position out of range");

   // A checksum byte always sends the parser back to hunting.
   assert property (@(posedge clock) disable iff (reset)
      step && at_check |=> pos_ff == POS_HUNT1)
      else $error("no return to hunt after checksum byte");

   // Collection starts only after a second sync byte.
   assert property (@(posedge clock) disable iff (reset)
      (pos_ff == POS_FIRST && $past(pos_ff) != POS_FIRST) |->
         ($past(pos_ff) == POS_HUNT2 && $past(rx_byte) == SYNC_BYTE && $past(step)))
      else $error("frame collection started without sync pair");

endmodule
